// File: rtl/rft_pkg.sv
package rft_pkg;

    localparam int VALUE_W    = 31;
    localparam int COUNT_W    = 16;
    localparam int DEPTH_DEF  = 1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] REPEAT_MIN = COUNT_W'(2);

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REP_A,
        S_REP_B,
        S_REP_C
    } t_state;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } t_entry;

endpackage

// File: rtl/rft_ram.sv
module rft_ram #(
    parameter int DEPTH = rft_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  rft_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output rft_pkg::t_entry o_rdata
);
    import rft_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/repeat_frequency_table.sv
// Channel   Ports                                    Transfer
// command   start, i_action, i_value                 start high while busy low
// result    o_valid, o_rep_value, o_rep_count,       o_valid high for one cycle
//           o_is_last, o_none_found, o_overflowed
//
// One item at a time; the table memory has one read and one write port and
// the scan reads one entry a cycle, so the time an add or a report takes
// grows with the entries in the table (used); a report result shows in the
// first cycle busy is low. A clear and an unused code finish without a scan.
// Reset is synchronous and leaves the table empty at once; the receiver
// cannot stall a result.
module repeat_frequency_table #(
    parameter int TABLE_DEPTH = rft_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic [rft_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_valid,
    output logic [rft_pkg::VALUE_W-1:0]  o_rep_value,
    output logic [rft_pkg::COUNT_W-1:0]  o_rep_count,
    output logic                         o_is_last,
    output logic                         o_none_found,
    output logic                         o_overflowed
);
    import rft_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state              r_state,     n_state;
    logic [CW-1:0]       r_used,      n_used;
    logic [AW-1:0]       r_cursor,    n_cursor;
    logic                r_ovf,       n_ovf;
    logic [VALUE_W-1:0]  r_value,     n_value;
    logic [CW-1:0]       r_idx,       n_idx;
    logic                r_pend,      n_pend;
    logic [AW-1:0]       r_pidx,      n_pidx;
    logic [AW-1:0]       r_found,     n_found;
    logic                r_done,      n_done;
    logic [VALUE_W-1:0]  r_rep_value, n_rep_value;
    logic [COUNT_W-1:0]  r_rep_count, n_rep_count;
    logic                r_is_last,   n_is_last;
    logic                r_none,      n_none;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    t_entry              ram_rdata;
    logic                hit;
    logic                more;

    rft_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cursor <= '0;
            r_ovf    <= 1'b0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cursor <= n_cursor;
            r_ovf    <= n_ovf;
            r_pend   <= n_pend;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_found     <= n_found;
        r_rep_value <= n_rep_value;
        r_rep_count <= n_rep_count;
        r_is_last   <= n_is_last;
        r_none      <= n_none;
    end

    assign more = r_idx < r_used;
    assign hit  = r_pend && ((r_state == S_ADD) ? (ram_rdata.value == r_value)
                                                : (ram_rdata.count >= REPEAT_MIN));

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_cursor    = r_cursor;
        n_ovf       = r_ovf;
        n_value     = r_value;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_done      = 1'b0;
        n_rep_value = r_rep_value;
        n_rep_count = r_rep_count;
        n_is_last   = r_is_last;
        n_none      = r_none;
        ram_we      = 1'b0;
        ram_waddr   = r_pidx;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
                if (start) begin
                    unique case (i_action)
                        ACT_ADD: begin
                            n_value = i_value;
                            n_idx   = '0;
                            n_state = S_ADD;
                        end
                        ACT_REPORT: begin
                            n_idx   = CW'(r_cursor);
                            n_state = S_REP_A;
                        end
                        ACT_CLEAR: begin
                            n_used   = '0;
                            n_cursor = '0;
                            n_ovf    = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD, S_REP_A, S_REP_B, S_REP_C: begin
                if (hit) begin
                    n_pend = 1'b0;
                    unique case (r_state)
                        S_ADD: begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_pidx;
                            ram_wdata.value = ram_rdata.value;
                            ram_wdata.count = (ram_rdata.count == COUNT_MAX) ? COUNT_MAX
                                            : ram_rdata.count + COUNT_ONE;
                            n_state         = S_IDLE;
                        end
                        S_REP_C: begin
                            n_is_last = 1'b0;
                            n_none    = 1'b0;
                            n_cursor  = r_found + AW'(1);
                            n_done    = 1'b1;
                            n_state   = S_IDLE;
                        end
                        default: begin
                            n_rep_value = ram_rdata.value;
                            n_rep_count = ram_rdata.count;
                            n_found     = r_pidx;
                            n_idx       = CW'(r_pidx) + CW'(1);
                            n_state     = S_REP_C;
                        end
                    endcase
                end else if (more) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                    unique case (r_state)
                        S_ADD: begin
                            if (r_used < CW'(TABLE_DEPTH)) begin
                                ram_we          = 1'b1;
                                ram_waddr       = r_used[AW-1:0];
                                ram_wdata.value = r_value;
                                ram_wdata.count = COUNT_ONE;
                                n_used          = r_used + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                        S_REP_C: begin
                            n_is_last = 1'b1;
                            n_none    = 1'b0;
                            n_cursor  = '0;
                            n_done    = 1'b1;
                            n_state   = S_IDLE;
                        end
                        default: begin
                            if (r_state == S_REP_A && r_cursor != '0) begin
                                n_idx   = '0;
                                n_state = S_REP_B;
                            end else begin
                                n_rep_value = '0;
                                n_rep_count = '0;
                                n_is_last   = 1'b1;
                                n_none      = 1'b1;
                                n_cursor    = '0;
                                n_done      = 1'b1;
                                n_state     = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_done;
    assign o_rep_value  = r_rep_value;
    assign o_rep_count  = r_rep_count;
    assign o_is_last    = r_is_last;
    assign o_none_found = r_none;
    assign o_overflowed = r_ovf;

    a_valid_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_REP_A || $past(r_state) == S_REP_B
                     || $past(r_state) == S_REP_C))
        else $error("result strobe without a report scan");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_none_found) |-> (o_is_last && o_rep_count == '0))
        else $error("empty report carries data");

    a_found_repeated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_none_found) |-> (o_rep_count >= REPEAT_MIN))
        else $error("reported entry is not repeated");

    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state != S_IDLE))
        else $error("read in flight while idle");

endmodule
